/* design/bpf_pkg.sv */
// Shared constants and types of the bone partition first-fit block.
package bpf_pkg;

  localparam int MAX_PARTITIONS      = 16;
  localparam int BONES_PER_PARTITION = 256;
  localparam int SLOTS_PER_VERTEX    = 4;
  localparam int VERTICES            = 3;
  localparam int TRI_SLOTS           = SLOTS_PER_VERTEX * VERTICES;
  localparam int PENDING_SLOTS       = SLOTS_PER_VERTEX * (VERTICES - 1);

  localparam int BONE_W  = 15;
  localparam int WEIGHT_W = 8;
  localparam int PART_W  = $clog2(MAX_PARTITIONS);
  localparam int SLOT_W  = $clog2(BONES_PER_PARTITION);
  localparam int CNT_W   = $clog2(BONES_PER_PARTITION + 1);
  localparam int OPEN_W  = $clog2(MAX_PARTITIONS + 1);
  localparam int TSLOT_W = $clog2(TRI_SLOTS);
  localparam int EXTRA_W = $clog2(TRI_SLOTS + 1);
  localparam int ADDR_W  = PART_W + SLOT_W;
  localparam int DEPTH   = MAX_PARTITIONS * BONES_PER_PARTITION;

  localparam int CFG_W    = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic REG_MAX_BONES = 1'b0;
  localparam logic [CFG_W-1:0] MAX_BONES_RESET = CFG_W'(256);

  typedef struct packed {
    logic [1:0]                             op;
    logic [SLOTS_PER_VERTEX-1:0][BONE_W-1:0] bone;
    logic [SLOTS_PER_VERTEX-1:0]            weighted;
    logic                                   last_vertex;
    logic [PART_W-1:0]                      read_partition;
    logic [SLOT_W-1:0]                      read_slot;
  } item_t;

  typedef struct packed {
    logic [PART_W-1:0] partition;
    logic              opened_new;
    logic              place_error;
    logic [BONE_W-1:0] read_bone;
    logic [CNT_W-1:0]  bone_count;
    logic [OPEN_W-1:0] partitions_open;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BONE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

/* design/bpf_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface bpf_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [bpf_pkg::BONE_W-1:0]  bone_index0;
  logic [bpf_pkg::BONE_W-1:0]  bone_index1;
  logic [bpf_pkg::BONE_W-1:0]  bone_index2;
  logic [bpf_pkg::BONE_W-1:0]  bone_index3;
  logic [bpf_pkg::WEIGHT_W-1:0] bone_weight0;
  logic [bpf_pkg::WEIGHT_W-1:0] bone_weight1;
  logic [bpf_pkg::WEIGHT_W-1:0] bone_weight2;
  logic [bpf_pkg::WEIGHT_W-1:0] bone_weight3;
  logic                        last_vertex;
  logic [bpf_pkg::PART_W-1:0]  read_partition;
  logic [bpf_pkg::SLOT_W-1:0]  read_slot;

  modport source (
    output valid, op, bone_index0, bone_index1, bone_index2, bone_index3,
           bone_weight0, bone_weight1, bone_weight2, bone_weight3,
           last_vertex, read_partition, read_slot,
    input  ready
  );
  modport sink (
    input  valid, op, bone_index0, bone_index1, bone_index2, bone_index3,
           bone_weight0, bone_weight1, bone_weight2, bone_weight3,
           last_vertex, read_partition, read_slot,
    output ready
  );
endinterface

interface bpf_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpf_pkg::PART_W-1:0] partition;
  logic                       opened_new;
  logic                       place_error;
  logic [bpf_pkg::BONE_W-1:0] read_bone;
  logic [bpf_pkg::CNT_W-1:0]  bone_count;
  logic [bpf_pkg::OPEN_W-1:0] partitions_open;

  modport source (
    output valid, partition, opened_new, place_error, read_bone, bone_count,
           partitions_open,
    input  ready
  );
  modport sink (
    input  valid, partition, opened_new, place_error, read_bone, bone_count,
           partitions_open,
    output ready
  );
endinterface

/* design/bpf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module bpf_ram #(
  parameter int Depth = 4096,
  parameter int Width = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bpf_regs.sv */
// APB-style configuration register holding the partition bone limit.
module bpf_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpf_pkg::PADDR_W-1:0] paddr,
  input  logic [bpf_pkg::PDATA_W-1:0] pwdata,
  output logic [bpf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [bpf_pkg::CFG_W-1:0]   max_bones_o
);

  logic [bpf_pkg::CFG_W-1:0] max_bones_q;
  logic                      sel_max;

  assign pready  = 1'b1;
  assign sel_max = (paddr[bpf_pkg::PADDR_W-1] == bpf_pkg::REG_MAX_BONES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bones_q <= bpf_pkg::MAX_BONES_RESET;
    end else if (psel && penable && pwrite && sel_max) begin
      max_bones_q <= pwdata[bpf_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = bpf_pkg::PDATA_W'(max_bones_q);
    end
  end

  assign max_bones_o = max_bones_q;

endmodule

/* design/bpf_core.sv */
// Sequencer: buffers vertices, scans partitions in the bone store, appends bones, serves reads and clears.
module bpf_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bpf_pkg::item_t            item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bpf_pkg::result_t          result_o,
  input  logic [bpf_pkg::CFG_W-1:0] max_bones_i,
  output bpf_pkg::ram_req_t         ram_req_o,
  input  logic [bpf_pkg::BONE_W-1:0] ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_EVAL, ST_APPEND, ST_RD_WAIT, ST_RES
  } state_e;

  state_e state_q;
  logic [bpf_pkg::TRI_SLOTS-1:0][bpf_pkg::BONE_W-1:0]     tri_bone_q;
  logic [bpf_pkg::TRI_SLOTS-1:0]                          tri_valid_q;
  logic [bpf_pkg::TRI_SLOTS-1:0]                          present_q;
  logic [bpf_pkg::PENDING_SLOTS-1:0][bpf_pkg::BONE_W-1:0] pend_bone_q;
  logic [bpf_pkg::PENDING_SLOTS-1:0]                      pend_valid_q;
  logic [1:0]                                            vpos_q;
  logic [bpf_pkg::MAX_PARTITIONS-1:0][bpf_pkg::CNT_W-1:0] size_q;
  logic [bpf_pkg::OPEN_W-1:0]                            open_q;
  logic [bpf_pkg::PART_W-1:0]                            part_q;
  logic                                                  new_q;
  logic                                                  err_q;
  logic                                                  is_read_q;
  logic                                                  rd_ok_q;
  logic [bpf_pkg::BONE_W-1:0]                            rbone_q;
  logic [bpf_pkg::CNT_W-1:0]                             idx_q;
  logic                                                  pend_q;
  logic [bpf_pkg::TSLOT_W-1:0]                           slot_q;
  logic                                                  out_valid_q;
  bpf_pkg::result_t                                      result_q;
  bpf_pkg::result_t                                      result_d;

  logic [bpf_pkg::CNT_W-1:0]   sz;
  logic [bpf_pkg::CNT_W-1:0]   limit;
  logic [bpf_pkg::CNT_W-1:0]   room;
  logic [bpf_pkg::EXTRA_W-1:0] extra;
  logic [bpf_pkg::TRI_SLOTS-1:0] first;
  logic                        do_append;
  logic                        accept;

  assign sz         = size_q[part_q];
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    limit = (max_bones_i > bpf_pkg::CFG_W'(bpf_pkg::BONES_PER_PARTITION)) ?
            bpf_pkg::CNT_W'(bpf_pkg::BONES_PER_PARTITION) : bpf_pkg::CNT_W'(max_bones_i);
    room  = (limit > sz) ? limit - sz : '0;
    extra = '0;
    for (int k = 0; k < bpf_pkg::TRI_SLOTS; k++) begin
      extra = extra + bpf_pkg::EXTRA_W'(tri_valid_q[k] && !present_q[k]);
    end
  end

  // A bone repeated within the triangle is appended only at its first slot.
  always_comb begin
    for (int i = 0; i < bpf_pkg::TRI_SLOTS; i++) begin
      first[i] = 1'b1;
      for (int j = 0; j < i; j++) begin
        if (tri_valid_q[j] && (tri_bone_q[j] == tri_bone_q[i])) begin
          first[i] = 1'b0;
        end
      end
    end
  end

  assign do_append = (state_q == ST_APPEND) && tri_valid_q[slot_q] &&
                     !present_q[slot_q] && first[slot_q];

  always_comb begin
    ram_req_o       = '0;
    ram_req_o.wdata = tri_bone_q[slot_q];
    ram_req_o.waddr = {part_q, sz[bpf_pkg::SLOT_W-1:0]};
    ram_req_o.we    = do_append;
    if (state_q == ST_IDLE) begin
      ram_req_o.raddr = {item_i.read_partition, item_i.read_slot};
      ram_req_o.re    = accept && (item_i.op == bpf_pkg::OP_READ);
    end else begin
      ram_req_o.raddr = {part_q, idx_q[bpf_pkg::SLOT_W-1:0]};
      ram_req_o.re    = (state_q == ST_SCAN) && (idx_q < sz);
    end
  end

  always_comb begin
    result_d = '0;
    result_d.partitions_open = open_q;
    if (is_read_q) begin
      result_d.read_bone  = rbone_q;
      result_d.bone_count = sz;
    end else if (err_q) begin
      result_d.place_error = 1'b1;
    end else begin
      result_d.partition  = part_q;
      result_d.opened_new = new_q;
      result_d.bone_count = sz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tri_bone_q   <= '0;
      tri_valid_q  <= '0;
      present_q    <= '0;
      pend_bone_q  <= '0;
      pend_valid_q <= '0;
      vpos_q       <= '0;
      size_q       <= '0;
      open_q       <= '0;
      part_q       <= '0;
      new_q        <= 1'b0;
      err_q        <= 1'b0;
      is_read_q    <= 1'b0;
      rd_ok_q      <= 1'b0;
      rbone_q      <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
      result_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (item_i.op)
              bpf_pkg::OP_CLEAR: begin
                size_q       <= '0;
                open_q       <= '0;
                pend_valid_q <= '0;
                vpos_q       <= '0;
              end
              bpf_pkg::OP_READ: begin
                part_q    <= item_i.read_partition;
                rd_ok_q   <= bpf_pkg::CNT_W'(item_i.read_slot) <
                             size_q[item_i.read_partition];
                is_read_q <= 1'b1;
                state_q   <= ST_RD_WAIT;
              end
              bpf_pkg::OP_PLACE: begin
                if (!item_i.last_vertex) begin
                  if (vpos_q < 2'(bpf_pkg::VERTICES - 1)) begin
                    for (int k = 0; k < bpf_pkg::SLOTS_PER_VERTEX; k++) begin
                      pend_bone_q[{vpos_q[0], 2'(k)}]  <= item_i.bone[k];
                      pend_valid_q[{vpos_q[0], 2'(k)}] <= item_i.weighted[k];
                    end
                    vpos_q <= vpos_q + 2'd1;
                  end
                end else begin
                  for (int k = 0; k < bpf_pkg::PENDING_SLOTS; k++) begin
                    tri_bone_q[k]  <= pend_bone_q[k];
                    tri_valid_q[k] <= pend_valid_q[k];
                  end
                  for (int k = 0; k < bpf_pkg::SLOTS_PER_VERTEX; k++) begin
                    tri_bone_q[bpf_pkg::PENDING_SLOTS + k]  <= item_i.bone[k];
                    tri_valid_q[bpf_pkg::PENDING_SLOTS + k] <= item_i.weighted[k];
                  end
                  pend_valid_q <= '0;
                  vpos_q       <= '0;
                  is_read_q    <= 1'b0;
                  err_q        <= 1'b0;
                  present_q    <= '0;
                  idx_q        <= '0;
                  pend_q       <= 1'b0;
                  part_q       <= '0;
                  if (open_q == '0) begin
                    new_q   <= 1'b1;
                    state_q <= ST_EVAL;
                  end else begin
                    new_q   <= 1'b0;
                    state_q <= ST_SCAN;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (pend_q) begin
            for (int k = 0; k < bpf_pkg::TRI_SLOTS; k++) begin
              if (ram_rdata_i == tri_bone_q[k]) begin
                present_q[k] <= 1'b1;
              end
            end
          end
          if (idx_q < sz) begin
            idx_q  <= idx_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          slot_q <= '0;
          if (extra == '0) begin
            if (new_q) begin
              open_q <= open_q + 1'b1;
            end
            state_q <= ST_RES;
          end else if (bpf_pkg::CNT_W'(extra) <= room) begin
            state_q <= ST_APPEND;
          end else if (new_q) begin
            err_q   <= 1'b1;
            state_q <= ST_RES;
          end else if (bpf_pkg::OPEN_W'(part_q) + 1'b1 < open_q) begin
            part_q    <= part_q + 1'b1;
            present_q <= '0;
            idx_q     <= '0;
            state_q   <= ST_SCAN;
          end else if (open_q < bpf_pkg::OPEN_W'(bpf_pkg::MAX_PARTITIONS)) begin
            // The next unopened partition is empty, so no scan is needed.
            part_q    <= open_q[bpf_pkg::PART_W-1:0];
            new_q     <= 1'b1;
            present_q <= '0;
          end else begin
            err_q   <= 1'b1;
            state_q <= ST_RES;
          end
        end
        ST_APPEND: begin
          if (do_append) begin
            size_q[part_q] <= sz + 1'b1;
          end
          if (slot_q == bpf_pkg::TSLOT_W'(bpf_pkg::TRI_SLOTS - 1)) begin
            if (new_q) begin
              open_q <= open_q + 1'b1;
            end
            state_q <= ST_RES;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        ST_RD_WAIT: begin
          rbone_q <= rd_ok_q ? ram_rdata_i : '0;
          state_q <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            result_q    <= result_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

/* design/bone_partition_first_fit.sv */
// A triangle placement takes the last vertex, then, for each open partition
// tried, scans its stored bones through the bone store's single read port, which
// returns one stored bone per cycle, and then evaluates whether the bones still
// missing fit; a fresh partition needs no scan. The append step walks the twelve
// triangle slots and writes the missing bones to the chosen partition, and then
// the result is delivered. The bone store needs no clearing pass after reset; a
// result may wait in the output register while the next transaction is taken.
module bone_partition_first_fit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bpf_in_if.sink                      in_if,
  bpf_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpf_pkg::PADDR_W-1:0] paddr,
  input  logic [bpf_pkg::PDATA_W-1:0] pwdata,
  output logic [bpf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  bpf_pkg::item_t    item;
  bpf_pkg::result_t  result;
  bpf_pkg::ram_req_t ram_req;
  logic [bpf_pkg::BONE_W-1:0] ram_rdata;
  logic [bpf_pkg::CFG_W-1:0]  max_bones;

  always_comb begin
    item.op             = in_if.op;
    item.bone[0]        = in_if.bone_index0;
    item.bone[1]        = in_if.bone_index1;
    item.bone[2]        = in_if.bone_index2;
    item.bone[3]        = in_if.bone_index3;
    item.weighted[0]    = (in_if.bone_weight0 != '0);
    item.weighted[1]    = (in_if.bone_weight1 != '0);
    item.weighted[2]    = (in_if.bone_weight2 != '0);
    item.weighted[3]    = (in_if.bone_weight3 != '0);
    item.last_vertex    = in_if.last_vertex;
    item.read_partition = in_if.read_partition;
    item.read_slot      = in_if.read_slot;
  end

  bpf_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_bones_o (max_bones)
  );

  bpf_ram #(
    .Depth (bpf_pkg::DEPTH),
    .Width (bpf_pkg::BONE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  bpf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .item_i      (item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .result_o    (result),
    .max_bones_i (max_bones),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  assign out_if.partition       = result.partition;
  assign out_if.opened_new      = result.opened_new;
  assign out_if.place_error     = result.place_error;
  assign out_if.read_bone       = result.read_bone;
  assign out_if.bone_count      = result.bone_count;
  assign out_if.partitions_open = result.partitions_open;

endmodule
